>>> rtl/pbo_pkg.sv
// ----------------------------------------------------------------------------
// pbo_pkg
// Shared types, constants and helpers for the polyBLEP oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package pbo_pkg;

  localparam int PhaseBits   = 32;
  localparam int OutFracBits = 21;
  localparam int AccBits     = 27;
  localparam int MulBits     = 33;
  localparam int QuoBits     = OutFracBits;

  localparam logic signed [AccBits-1:0] OneQ   = AccBits'(1) <<< OutFracBits;
  localparam logic signed [AccBits-1:0] SatMax = AccBits'(8388607);
  localparam logic signed [AccBits-1:0] SatMin = -AccBits'(8388608);

  localparam logic [MulBits-1:0] SinA = MulBits'(1686629713);
  localparam logic [MulBits-1:0] SinB = MulBits'(688904866);
  localparam logic [MulBits-1:0] SinC = MulBits'(76016977);

  localparam logic [PhaseBits-1:0] PhaseHalf = PhaseBits'(1) << (PhaseBits - 1);

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SAW      = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_t;

  typedef enum logic {
    REG_INCREMENT = 1'b0,
    REG_WAVEFORM  = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SX2,
    S_SC,
    S_SB,
    S_SA,
    S_SR,
    S_BSEL,
    S_DIV,
    S_BSQ,
    S_BACC,
    S_TRI,
    S_TRI2,
    S_OUT
  } state_t;

  function automatic logic signed [23:0] sat24(input logic signed [AccBits-1:0] v);
    logic signed [23:0] r;
    if (v > SatMax) r = 24'sh7fffff;
    else if (v < SatMin) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/polyblep_oscillator_top.sv
// ----------------------------------------------------------------------------
// polyblep_oscillator_top
// Band-limited oscillator: sine, polyBLEP saw and square, integrated triangle.
// ----------------------------------------------------------------------------
// One tick transfer yields one Q2.21 sample. The block works on one tick at a
// time around a single shared 33x33 multiplier and a one-bit-per-cycle
// divider for the BLEP ratio, which each BLEP window hit runs once; a
// stalled receiver holds the block until it takes the sample.
`default_nettype none

module polyblep_oscillator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [23:0] sample
);
  import pbo_pkg::*;

  state_t state, state_next;

  logic [30:0]              inc;
  wave_t                    wave;
  logic [PhaseBits-1:0]     phase_acc;
  logic [PhaseBits-1:0]     ph;
  logic signed [23:0]       tsum;
  logic signed [AccBits-1:0] acc;
  logic signed [2*MulBits-1:0] prod;
  logic [30:0]              x2;
  logic [PhaseBits-1:0]     rem;
  logic [QuoBits-1:0]       q;
  logic [4:0]               cnt;
  logic                     bidx;
  logic                     near0_r;

  logic signed [MulBits-1:0] mul_a, mul_b;
  logic [PhaseBits-1:0] ph_new, bph, gap, rem2;
  logic [30:0] xval;
  logic near0, near1, more, is_tri, accept;
  logic [32:0] t_fin;
  logic [23:0] y_rnd;
  logic [21:0] sq_rnd;
  logic signed [AccBits-1:0] bval, step, tsum_sum;
  logic signed [2*MulBits-1:0] tri_sh;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign sample = sat24(acc);

  assign ph_new = restart ? '0 : phase_acc;
  assign xval = ph[30] ? (31'(1) << 30) - {1'b0, ph[29:0]} : {1'b0, ph[29:0]};
  assign is_tri = (wave == WAVE_TRIANGLE);
  assign more = (wave == WAVE_SQUARE || is_tri) && !bidx;

  assign bph   = bidx ? ph + PhaseHalf : ph;
  assign near0 = (inc != '0) && (bph < {1'b0, inc});
  assign gap   = '0 - bph;
  assign near1 = (inc != '0) && !near0 && (gap < {1'b0, inc});
  assign rem2  = {rem[PhaseBits-2:0], 1'b0};

  assign sq_rnd = 22'((prod + (66'sd1 <<< (OutFracBits - 1))) >>> OutFracBits);
  assign bval = near0_r
    ? (AccBits'({q, 1'b0}) - AccBits'(sq_rnd) - OneQ)
    : (OneQ - AccBits'({q, 1'b0}) + AccBits'(sq_rnd));

  assign t_fin = prod[62:30];
  assign y_rnd = 24'((t_fin + 33'd256) >> 9);

  assign tri_sh = (prod <<< 2) + (66'sd1 <<< 31);
  assign step = tri_sh[58:32];
  assign tsum_sum = AccBits'(tsum) + step;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = (wave == WAVE_SINE) ? S_SX2 : S_BSEL;
      end
      S_SX2: state_next = S_SC;
      S_SC:  state_next = S_SB;
      S_SB:  state_next = S_SA;
      S_SA:  state_next = S_SR;
      S_SR:  state_next = S_OUT;
      S_BSEL: begin
        if (near0 || near1) state_next = S_DIV;
        else if (more) state_next = S_BSEL;
        else state_next = is_tri ? S_TRI : S_OUT;
      end
      S_DIV: begin
        if (cnt == 5'(QuoBits - 1)) state_next = S_BSQ;
      end
      S_BSQ: state_next = S_BACC;
      S_BACC: begin
        if (more) state_next = S_BSEL;
        else state_next = is_tri ? S_TRI : S_OUT;
      end
      S_TRI:  state_next = S_TRI2;
      S_TRI2: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SX2: begin
        mul_a = MulBits'(xval);
        mul_b = MulBits'(xval);
      end
      S_SC: begin
        mul_a = SinC;
        mul_b = MulBits'(prod[60:30]);
      end
      S_SB: begin
        mul_a = SinB - MulBits'(prod[61:30]);
        mul_b = MulBits'(x2);
      end
      S_SA: begin
        mul_a = SinA - MulBits'(prod[61:30]);
        mul_b = MulBits'(xval);
      end
      S_BSQ: begin
        mul_a = MulBits'(q);
        mul_b = MulBits'(q);
      end
      S_TRI: begin
        mul_a = MulBits'(inc);
        mul_b = MulBits'(sat24(acc));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= S_IDLE;
      inc       <= 31'd42852281;
      wave      <= WAVE_SINE;
      phase_acc <= '0;
      tsum      <= 24'sd2097152;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (reg_index_t'(cfg_index))
          REG_INCREMENT: inc <= cfg_data;
          REG_WAVEFORM:  wave <= wave_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (accept) begin
        phase_acc <= ph_new + {1'b0, inc};
        if (restart) tsum <= 24'sd2097152;
      end
      if (state == S_TRI2) tsum <= sat24(tsum_sum);
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ph   <= ph_new;
          bidx <= 1'b0;
          if (wave == WAVE_SAW)
            acc <= AccBits'({ph_new[PhaseBits-1:PhaseBits-OutFracBits], 1'b0}) - OneQ;
          else
            acc <= ph_new[PhaseBits-1] ? OneQ : -OneQ;
        end
      end
      S_SC: x2 <= prod[60:30];
      S_SR: acc <= ph[31] ? -AccBits'(y_rnd) : AccBits'(y_rnd);
      S_BSEL: begin
        near0_r <= near0;
        rem     <= near0 ? bph : gap;
        q       <= '0;
        cnt     <= '0;
        if (!(near0 || near1) && more) bidx <= 1'b1;
      end
      S_DIV: begin
        cnt <= cnt + 5'd1;
        if (rem2 >= {1'b0, inc}) begin
          rem <= rem2 - {1'b0, inc};
          q   <= {q[QuoBits-2:0], 1'b1};
        end else begin
          rem <= rem2;
          q   <= {q[QuoBits-2:0], 1'b0};
        end
      end
      S_BACC: begin
        acc <= bidx ? acc + bval : acc - bval;
        if (more) bidx <= 1'b1;
      end
      S_TRI2: acc <= AccBits'(sat24(tsum_sum));
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while holding a result");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready) else $error("ready right after a tick transfer");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt < 5'(QuoBits) && q < (QuoBits'(1) << cnt) + 0 || cnt == 5'd0)
    ) else $error("divider count out of range");

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (!is_tri && !accept) |=> $stable(tsum)) else $error("triangle sum moved");

endmodule

`default_nettype wire
